[design/awdh_pkg.sv]
package awdh_pkg;

	// Default sizes of the histogram store.
	localparam int CHANNELS_DEF    = 16;
	localparam int BINS_DEF        = 4096;
	localparam int COUNT_WIDTH_DEF = 32;

	// Field widths of the stream beats.
	localparam int FUNC_W   = 2;
	localparam int KIND_W   = 3;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 88;
	localparam int TARGET_W = 32;
	localparam int EVENTS_W = 32;

	// Operation codes carried in the input tuser.
	localparam logic [FUNC_W-1:0] FUNC_WORD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Readout word type codes found in bits 26..24.
	localparam logic [2:0] CODE_DATUM  = 3'd0;
	localparam logic [2:0] CODE_HEADER = 3'd2;
	localparam logic [2:0] CODE_EOE    = 3'd4;

	// Result kinds carried in the output tuser.
	localparam logic [KIND_W-1:0] KIND_DATUM   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EOE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic commit;
		logic clr_init;
		logic sweep;
		logic load_clr;
	} awdh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              out_free;
		logic              sweep_last;
	} awdh_sts_t;

endpackage

[design/adc_word_decode_histogrammer.sv]
// The bin is read at the accepting edge and the result is loaded into the output
// register from the execute state once the output is free. A new item is taken
// only after the last one is committed, as the single histogram memory port
// does a read and then a write. A clear zeroes every bin and then answers.
// Reset: asynchronous, active low; afterwards a clearing pass over every bin
// zeroes the memory, no input is taken, configuration writes are.
module adc_word_decode_histogrammer #(
	parameter int CHANNELS    = awdh_pkg::CHANNELS_DEF,
	parameter int BINS        = awdh_pkg::BINS_DEF,
	parameter int COUNT_WIDTH = awdh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// data_word[31:0], read_channel[35:32], read_bin[47:36]
	input  logic [awdh_pkg::S_DATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [awdh_pkg::FUNC_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// channel[3:0], adc_value[15:4], event_count[47:16], stopped[48],
	// bin_count[80:49], zero fill above
	output logic [awdh_pkg::M_DATA_W-1:0] m_tdata,
	// word_kind[2:0]
	output logic [awdh_pkg::KIND_W-1:0]   m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [awdh_pkg::TARGET_W-1:0] cfg_data
);

	awdh_pkg::awdh_cmd_t cmd;
	awdh_pkg::awdh_sts_t sts;

	// The target register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	awdh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	awdh_datapath #(
		.CHANNELS    (CHANNELS),
		.BINS        (BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[design/awdh_ram.sv]
module awdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[design/awdh_ctrl.sv]
module awdh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  awdh_pkg::awdh_sts_t sts,
	output awdh_pkg::awdh_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLR,
		S_REPLY
	} state_t;

	state_t state_q;
	state_t state_n;

	assign s_tready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_n    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.func == awdh_pkg::FUNC_CLEAR) begin
					cmd.clr_init = 1'b1;
					state_n      = S_CLR;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_n = S_REPLY;
				end
			end
			S_REPLY: begin
				if (sts.out_free) begin
					cmd.load_clr = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

[design/awdh_datapath.sv]
module awdh_datapath #(
	parameter int CHANNELS    = awdh_pkg::CHANNELS_DEF,
	parameter int BINS        = awdh_pkg::BINS_DEF,
	parameter int COUNT_WIDTH = awdh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  awdh_pkg::awdh_cmd_t             cmd,
	output awdh_pkg::awdh_sts_t             sts,
	input  logic [awdh_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [awdh_pkg::FUNC_W-1:0]     s_tuser,
	input  logic                            cfg_valid,
	input  logic [awdh_pkg::TARGET_W-1:0]   cfg_data,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [awdh_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [awdh_pkg::KIND_W-1:0]     m_tuser
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIN_W  = $clog2(BINS);
	localparam int ADDR_W = CH_W + BIN_W;
	localparam int DEPTH  = (1 << CH_W) << BIN_W;
	localparam logic [4:0]  CH_LIM  = 5'(CHANNELS);
	localparam logic [12:0] BIN_LIM = 13'(BINS);
	localparam int EW = awdh_pkg::EVENTS_W;

	// Input beat fields.
	logic [31:0] word;
	logic [3:0]  rd_ch;
	logic [11:0] rd_bin;
	logic [3:0]  sel_ch;
	logic [11:0] sel_bin;
	logic        sel_ok;
	logic [ADDR_W-1:0] sel_addr;

	// Item registers latched on accept.
	logic [awdh_pkg::FUNC_W-1:0] func_q;
	logic [2:0]        code_q;
	logic [3:0]        ch_q;
	logic [11:0]       val_q;
	logic              ok_q;
	logic [ADDR_W-1:0] addr_q;

	// Block state.
	logic [awdh_pkg::TARGET_W-1:0] target_q;
	logic [EW-1:0]     events_q;
	logic              halted_q;
	logic [ADDR_W-1:0] sweep_q;

	// Memory port.
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] bin_inc;
	logic                   hi_any;
	logic [31:0]            bin_sat;

	// Next result and state.
	logic [awdh_pkg::KIND_W-1:0] kind_n;
	logic [3:0]    ch_n;
	logic [11:0]   val_n;
	logic [31:0]   bin_n;
	logic [EW-1:0] events_n;
	logic          halted_n;
	logic          hist_we;

	// Output register.
	logic                          m_valid_q;
	logic [awdh_pkg::KIND_W-1:0]   o_kind_q;
	logic [3:0]                    o_ch_q;
	logic [11:0]                   o_val_q;
	logic [EW-1:0]                 o_events_q;
	logic                          o_stop_q;
	logic [31:0]                   o_bin_q;
	logic                          out_free;

	// Decode the beat: bin address for a read or for a datum word.
	assign word   = s_tdata[31:0];
	assign rd_ch  = s_tdata[35:32];
	assign rd_bin = s_tdata[47:36];

	always_comb begin
		if (s_tuser == awdh_pkg::FUNC_READ) begin
			sel_ch  = rd_ch;
			sel_bin = rd_bin;
		end else begin
			sel_ch  = word[20:17];
			sel_bin = word[11:0];
		end
		sel_ok   = ({1'b0, sel_ch} < CH_LIM) && ({1'b0, sel_bin} < BIN_LIM);
		sel_addr = {sel_ch[CH_W-1:0], sel_bin[BIN_W-1:0]};
	end

	// Saturate a wide bin count to the 32-bit result field.
	generate
		if (COUNT_WIDTH > 32) begin : g_wide
			assign hi_any = |ram_rdata[COUNT_WIDTH-1:32];
		end else begin : g_narrow
			assign hi_any = 1'b0;
		end
	endgenerate

	assign bin_sat = hi_any ? '1 : 32'(ram_rdata);
	assign bin_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

	// Work out the result of the latched item.
	always_comb begin
		kind_n   = awdh_pkg::KIND_NONE;
		ch_n     = '0;
		val_n    = '0;
		bin_n    = '0;
		events_n = events_q;
		halted_n = halted_q;
		hist_we  = 1'b0;
		case (func_q)
			awdh_pkg::FUNC_WORD: begin
				if (halted_q) begin
					kind_n = awdh_pkg::KIND_IGNORED;
				end else begin
					unique case (code_q)
						awdh_pkg::CODE_DATUM: begin
							kind_n  = awdh_pkg::KIND_DATUM;
							ch_n    = ch_q;
							val_n   = val_q;
							hist_we = ok_q;
						end
						awdh_pkg::CODE_HEADER: begin
							kind_n = awdh_pkg::KIND_HEADER;
						end
						awdh_pkg::CODE_EOE: begin
							kind_n = awdh_pkg::KIND_EOE;
							if (events_q != '1) begin
								events_n = events_q + EW'(1);
								if ((target_q != '0) && (events_n == target_q)) begin
									halted_n = 1'b1;
								end
							end
						end
						default: begin
							kind_n = awdh_pkg::KIND_OTHER;
						end
					endcase
				end
			end
			awdh_pkg::FUNC_READ: begin
				bin_n = ok_q ? bin_sat : '0;
			end
			default: begin
				kind_n = awdh_pkg::KIND_NONE;
			end
		endcase
	end

	// Memory port: read on accept, write back on commit, zero on sweep.
	always_comb begin
		ram_we    = (cmd.commit && hist_we) || cmd.sweep;
		ram_wdata = cmd.sweep ? '0 : bin_inc;
		if (cmd.accept) begin
			ram_addr = sel_addr;
		end else if (cmd.sweep) begin
			ram_addr = sweep_q;
		end else begin
			ram_addr = addr_q;
		end
	end

	awdh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (cmd.accept),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Item registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= word[26:24];
			ch_q   <= word[20:17];
			val_q  <= word[11:0];
			ok_q   <= sel_ok;
			addr_q <= sel_addr;
		end
	end

	// Control state: operation, target, event counter, halt, sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q   <= awdh_pkg::FUNC_WORD;
			target_q <= '0;
			events_q <= '0;
			halted_q <= 1'b0;
			sweep_q  <= '0;
		end else begin
			if (cmd.accept) begin
				func_q <= s_tuser;
			end
			if (cfg_valid) begin
				target_q <= cfg_data;
			end
			if (cmd.clr_init) begin
				events_q <= '0;
				halted_q <= 1'b0;
				sweep_q  <= '0;
			end else if (cmd.commit) begin
				events_q <= events_n;
				halted_q <= halted_n;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
		end
	end

	assign out_free = !m_valid_q || m_tready;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.load_clr) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_kind_q   <= kind_n;
			o_ch_q     <= ch_n;
			o_val_q    <= val_n;
			o_events_q <= events_n;
			o_stop_q   <= halted_n;
			o_bin_q    <= bin_n;
		end else if (cmd.load_clr) begin
			o_kind_q   <= awdh_pkg::KIND_NONE;
			o_ch_q     <= '0;
			o_val_q    <= '0;
			o_events_q <= events_q;
			o_stop_q   <= halted_q;
			o_bin_q    <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tdata  = {7'd0, o_bin_q, o_stop_q, o_events_q, o_val_q, o_ch_q};

	assign sts.func       = func_q;
	assign sts.out_free   = out_free;
	assign sts.sweep_last = &sweep_q;

endmodule

[design/awdh_checker.sv]
module awdh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result beat holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// The input is ready only in the idle state, so no beat is taken right after one.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in back-to-back cycles");

	// Only a datum reports channel and value.
	a_datum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != awdh_pkg::KIND_DATUM) |-> (m_tdata[15:0] == 16'd0))
		else $error("decoded fields set on a non-datum result");

	// A bin count appears only on a result that is not a readout word.
	a_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != awdh_pkg::KIND_NONE) |-> (m_tdata[80:49] == 32'd0))
		else $error("bin count set on a readout word result");

	// An ignored word is only reported once acquisition has stopped.
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == awdh_pkg::KIND_IGNORED) |-> m_tdata[48])
		else $error("word ignored while not stopped");

endmodule

bind adc_word_decode_histogrammer awdh_checker u_awdh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	// The spare operation code has no name in the package.
	localparam logic [awdh_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [awdh_pkg::FUNC_W-1:0] func;
		logic [31:0]                 word;
		logic [3:0]                  rch;
		logic [11:0]                 rbin;
	} item_t;

	typedef struct packed {
		logic [awdh_pkg::KIND_W-1:0]   kind;
		logic [3:0]                    channel;
		logic [11:0]                   adc_value;
		logic [awdh_pkg::EVENTS_W-1:0] events;
		logic                          stopped;
		logic [31:0]                   bin_count;
	} result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [awdh_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic [awdh_pkg::FUNC_W-1:0]     s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [awdh_pkg::M_DATA_W-1:0]   m_tdata;
	logic [awdh_pkg::KIND_W-1:0]     m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [awdh_pkg::TARGET_W-1:0]   cfg_data = '0;

	// Shadow copy of the block's state.
	logic [31:0]                   hist_bins [0:65535];
	logic [awdh_pkg::EVENTS_W-1:0] evt_count;
	logic                          acq_halted;
	logic [awdh_pkg::TARGET_W-1:0] target_reg;

	item_t       beat_queue[$];
	result_t     predicted_results[$];
	item_t       cur_item;
	bit          steady_flow = 1'b0;
	int unsigned src_gap;
	int unsigned sink_wait;
	int unsigned hold_left;
	int unsigned results_seen;
	int unsigned draw;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned rnd_clears = 0;

	adc_word_decode_histogrammer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Zero every bin, the event counter and the halt.
	function automatic void clear_histograms();
		foreach (hist_bins[i]) hist_bins[i] = '0;
		evt_count = '0;
		acq_halted = 1'b0;
	endfunction

	// Expected answer to one accepted beat; updates the shadow state.
	function automatic result_t histogram_step(input item_t it);
		result_t r;
		logic [15:0] idx;
		r = '0;
		r.kind = awdh_pkg::KIND_NONE;
		case (it.func)
			awdh_pkg::FUNC_WORD: begin
				if (acq_halted) begin
					r.kind = awdh_pkg::KIND_IGNORED;
				end else begin
					case (it.word[26:24])
						awdh_pkg::CODE_DATUM: begin
							r.kind = awdh_pkg::KIND_DATUM;
							r.channel = it.word[20:17];
							r.adc_value = it.word[11:0];
							idx = {it.word[20:17], it.word[11:0]};
							if (hist_bins[idx] != '1) hist_bins[idx] = hist_bins[idx] + 1;
						end
						awdh_pkg::CODE_HEADER: begin
							r.kind = awdh_pkg::KIND_HEADER;
						end
						awdh_pkg::CODE_EOE: begin
							r.kind = awdh_pkg::KIND_EOE;
							if (evt_count != '1) begin
								evt_count = evt_count + 1;
								if (target_reg != 0 && evt_count == target_reg) acq_halted = 1'b1;
							end
						end
						default: begin
							r.kind = awdh_pkg::KIND_OTHER;
						end
					endcase
				end
			end
			awdh_pkg::FUNC_READ: begin
				r.bin_count = hist_bins[{it.rch, it.rbin}];
			end
			awdh_pkg::FUNC_CLEAR: begin
				clear_histograms();
			end
			default: begin
			end
		endcase
		r.events = evt_count;
		r.stopped = acq_halted;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Input driver: one beat per item, with a random gap after each outside steady flow.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) predicted_results.push_back(histogram_step(cur_item));
			if (s_tvalid && !s_tready) begin
				// Hold the beat until it is taken.
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (beat_queue.size() != 0) begin
				cur_item = beat_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cur_item.rbin, cur_item.rch, cur_item.word};
				s_tuser <= cur_item.func;
				src_gap <= steady_flow ? 0 : $urandom_range(0, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor with random stalls and two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (predicted_results.size() == 0) begin
					$error("result beat arrived with no prediction pending");
					mismatches++;
				end else begin
					result_t e;
					e = predicted_results.pop_front();
					check_field("word_kind", 32'(e.kind), 32'(m_tuser));
					check_field("channel", 32'(e.channel), 32'(m_tdata[3:0]));
					check_field("adc_value", 32'(e.adc_value), 32'(m_tdata[15:4]));
					check_field("event_count", e.events, m_tdata[47:16]);
					check_field("stopped", 32'(e.stopped), 32'(m_tdata[48]));
					check_field("bin_count", e.bin_count, m_tdata[80:49]);
				end
			end
			if (m_tvalid && m_tready && (results_seen == 400 || results_seen == 1000)) begin
				hold_left <= 800;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				draw = steady_flow ? 0 : $urandom_range(0, 6);
				if (draw == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					sink_wait <= draw - 1;
				end
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic item_t word_item(input logic [31:0] w);
		item_t it;
		it.func = awdh_pkg::FUNC_WORD;
		it.word = w;
		it.rch = 4'($urandom_range(0, 15));
		it.rbin = 12'($urandom_range(0, 4095));
		return it;
	endfunction

	function automatic item_t op_item(input logic [awdh_pkg::FUNC_W-1:0] f,
			input logic [3:0] ch, input logic [11:0] bin);
		item_t it;
		it.func = f;
		it.word = $urandom;
		it.rch = ch;
		it.rbin = bin;
		return it;
	endfunction

	function automatic logic [31:0] coded_word(input logic [2:0] code);
		logic [31:0] w;
		w = $urandom;
		w[26:24] = code;
		return w;
	endfunction

	// Datum values cluster on a few bins at both ends so that reads find counts.
	function automatic logic [11:0] hot_value();
		logic [11:0] v;
		if ($urandom_range(0, 3) == 0) v = 12'($urandom_range(0, 4095));
		else v = 12'($urandom_range(0, 7)) | (($urandom_range(0, 1) != 0) ? 12'hff8 : 12'h000);
		return v;
	endfunction

	function automatic logic [31:0] datum_word(input logic [3:0] ch, input logic [11:0] v);
		logic [31:0] w;
		w = coded_word(awdh_pkg::CODE_DATUM);
		w[20:17] = ch;
		w[11:0] = v;
		return w;
	endfunction

	task automatic write_target(input logic [awdh_pkg::TARGET_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		target_reg = v;
	endtask

	// Sampled away from the rising edge so that driver and monitor updates have settled.
	task automatic wait_idle();
		while (beat_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly complete events with random content, the rest noise.
	task automatic gen_phase(input int unsigned n);
		int unsigned pushed;
		int unsigned k;
		int unsigned pick;
		pushed = 0;
		while (pushed < n) begin
			if ($urandom_range(0, 9) < 6) begin
				k = $urandom_range(1, 6);
				beat_queue.push_back(word_item(coded_word(awdh_pkg::CODE_HEADER)));
				repeat (k) beat_queue.push_back(word_item(datum_word(
					4'($urandom_range(0, 15)), hot_value())));
				beat_queue.push_back(word_item(coded_word(awdh_pkg::CODE_EOE)));
				pushed += k + 2;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					beat_queue.push_back(word_item($urandom));
				else if (pick < 5)
					beat_queue.push_back(op_item(awdh_pkg::FUNC_READ,
						4'($urandom_range(0, 15)), hot_value()));
				else if (pick < 7)
					beat_queue.push_back(op_item(awdh_pkg::FUNC_READ,
						4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095))));
				else if (pick < 8)
					beat_queue.push_back(op_item(FUNC_SPARE, 4'($urandom), 12'($urandom)));
				else if ($urandom_range(0, 39) == 0 && rnd_clears < 2) begin
					beat_queue.push_back(op_item(awdh_pkg::FUNC_CLEAR, 4'($urandom),
						12'($urandom)));
					rnd_clears++;
				end else
					beat_queue.push_back(word_item(datum_word(4'($urandom_range(0, 15)),
						hot_value())));
				pushed++;
			end
		end
	endtask

	initial begin
		clear_histograms();
		target_reg = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: halt after three events.
		write_target(32'd3);
		beat_queue.push_back(word_item(32'h0000_0000));
		beat_queue.push_back(word_item(32'hf8ff_ffff));
		beat_queue.push_back(word_item(32'h001e_0fff));
		beat_queue.push_back(word_item(32'h0200_0000));
		beat_queue.push_back(word_item(32'hfaff_ffff));
		beat_queue.push_back(word_item(32'h0100_0000));
		beat_queue.push_back(word_item(32'h0300_0000));
		beat_queue.push_back(word_item(32'h0500_0000));
		beat_queue.push_back(word_item(32'h0600_0000));
		beat_queue.push_back(word_item(32'hffff_ffff));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'hf, 12'hfff));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'h0, 12'h000));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'h7, 12'd100));
		beat_queue.push_back(op_item(FUNC_SPARE, 4'h0, 12'h000));
		beat_queue.push_back(word_item(32'h0400_0000));
		beat_queue.push_back(word_item(32'hfcff_ffff));
		beat_queue.push_back(word_item(32'h0400_0000));
		// Halted: readout words are ignored, reads still answer.
		beat_queue.push_back(word_item(32'h0002_0005));
		beat_queue.push_back(word_item(32'h0400_0000));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'hf, 12'hfff));
		// A clear releases the halt.
		beat_queue.push_back(op_item(awdh_pkg::FUNC_CLEAR, 4'hf, 12'hfff));
		beat_queue.push_back(word_item(32'h0002_0005));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'h1, 12'd5));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_READ, 4'hf, 12'hfff));
		beat_queue.push_back(word_item(32'h0400_0000));
		wait_idle();

		// Never stop.
		write_target(32'd0);
		gen_phase(350);
		wait_idle();

		// Largest target, no random idling on either side.
		steady_flow = 1'b1;
		write_target(32'hffff_ffff);
		gen_phase(300);
		wait_idle();
		steady_flow = 1'b0;

		// Target already passed by the count: no halt.
		write_target(32'd5);
		gen_phase(250);
		wait_idle();

		// Halt on the first event after a clear.
		write_target(32'd1);
		beat_queue.push_back(op_item(awdh_pkg::FUNC_CLEAR, 4'($urandom), 12'($urandom)));
		gen_phase(30);
		wait_idle();

		// Halt somewhere inside the phase.
		write_target($urandom_range(20, 40));
		beat_queue.push_back(op_item(awdh_pkg::FUNC_CLEAR, 4'($urandom), 12'($urandom)));
		gen_phase(250);
		wait_idle();

		write_target(32'd0);
		beat_queue.push_back(op_item(awdh_pkg::FUNC_CLEAR, 4'($urandom), 12'($urandom)));
		gen_phase(250);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
design/awdh_pkg.sv
design/awdh_ram.sv
design/awdh_ctrl.sv
design/awdh_datapath.sv
design/adc_word_decode_histogrammer.sv
design/awdh_checker.sv
tb/tb_top.sv
